// File: hdl/utc_pkg.sv
// Shared types and constants for the Unicode transcoder.
package utc_pkg;

  typedef enum logic [1:0] {
    FMT_UTF8  = 2'd0,
    FMT_UTF16 = 2'd1,
    FMT_UTF32 = 2'd2
  } utc_fmt_t;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_SRC_FMT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TGT_FMT = 2'd1;

  localparam logic [31:0] QMARK     = 32'h0000_003F;
  localparam logic [31:0] CP_MAX    = 32'h0010_FFFF;
  localparam logic [20:0] CP_SUPP   = 21'h01_0000;

  typedef struct packed {
    logic [31:0] code_unit;
    logic        end_of_text;
  } utc_in_t;

  typedef struct packed {
    logic [31:0] out_unit;
    logic        last_of_run;
    logic        error;
  } utc_out_t;

  // One decoded step handed from front to back
  typedef struct packed {
    logic        pre_err;   // '?' with error ahead of the codepoint
    logic        cp_vld;
    logic        cp_big;    // beyond the Unicode range
    logic [20:0] cp;
    logic        post_err;  // '?' with error for a truncated sequence
  } utc_entry_t;

endpackage

// File: hdl/utc_front.sv
// Front end: configuration registers and source decoding into codepoint entries.
module utc_front
  import utc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  acc,
  input  utc_in_t               in_data,
  output logic                  push,
  output utc_entry_t            entry,
  output logic [1:0]            tgt_fmt
);

  logic [1:0]  src_fmt_r, tgt_fmt_r;
  logic [20:0] pcp_r, pcp_nxt;
  logic [1:0]  rem_r, rem_nxt;
  logic        hs_r, hs_nxt;
  logic [9:0]  hsb_r, hsb_nxt;

  logic [7:0]  b;
  logic [15:0] w;
  logic        done;

  assign tgt_fmt = tgt_fmt_r;
  assign b = in_data.code_unit[7:0];
  assign w = in_data.code_unit[15:0];

  always_comb begin
    pcp_nxt = pcp_r;
    rem_nxt = rem_r;
    hs_nxt  = hs_r;
    hsb_nxt = hsb_r;
    done    = 1'b0;
    entry   = '0;
    case (src_fmt_r)
      FMT_UTF8: begin
        if (rem_r != 2'd0) begin
          pcp_nxt = {pcp_r[14:0], b[5:0]};
          rem_nxt = rem_r - 2'd1;
          if (rem_r == 2'd1) begin
            entry.cp_vld = 1'b1;
            entry.cp     = pcp_nxt;
            entry.cp_big = {11'd0, pcp_nxt} > CP_MAX;
            pcp_nxt      = '0;
          end
        end else if (!b[7]) begin
          entry.cp_vld = 1'b1;
          entry.cp     = {13'd0, b};
        end else if (b[7:5] == 3'b110) begin
          pcp_nxt = {16'd0, b[4:0]};
          rem_nxt = 2'd1;
        end else if (b[7:4] == 4'b1110) begin
          pcp_nxt = {17'd0, b[3:0]};
          rem_nxt = 2'd2;
        end else if (b[7:3] == 5'b11110) begin
          pcp_nxt = {18'd0, b[2:0]};
          rem_nxt = 2'd3;
        end else begin
          entry.pre_err = 1'b1;
        end
      end
      FMT_UTF16: begin
        if (hs_r) begin
          hs_nxt  = 1'b0;
          hsb_nxt = '0;
          if (w[15:10] == 6'b110111) begin
            entry.cp_vld = 1'b1;
            entry.cp     = CP_SUPP + {1'b0, hsb_r, w[9:0]};
            done         = 1'b1;
          end else begin
            entry.pre_err = 1'b1;
          end
        end
        if (!done) begin
          if (w[15:11] != 5'b11011) begin
            entry.cp_vld = 1'b1;
            entry.cp     = {5'd0, w};
          end else if (!w[10]) begin
            hs_nxt  = 1'b1;
            hsb_nxt = w[9:0];
          end else begin
            // lone low surrogate; a held high one never reaches here
            entry.pre_err = 1'b1;
          end
        end
      end
      default: begin
        entry.cp_vld = 1'b1;
        entry.cp     = in_data.code_unit[20:0];
        entry.cp_big = in_data.code_unit > CP_MAX;
      end
    endcase
    if (in_data.end_of_text) begin
      entry.post_err = (rem_nxt != 2'd0) || hs_nxt;
      pcp_nxt = '0;
      rem_nxt = '0;
      hs_nxt  = 1'b0;
      hsb_nxt = '0;
    end
  end

  assign push = acc && (entry.pre_err || entry.cp_vld || entry.post_err);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_fmt_r <= FMT_UTF8;
      tgt_fmt_r <= FMT_UTF16;
      pcp_r     <= '0;
      rem_r     <= '0;
      hs_r      <= 1'b0;
      hsb_r     <= '0;
    end else if (cfg_we) begin
      if (cfg_index == REG_SRC_FMT) begin
        src_fmt_r <= cfg_data;
        pcp_r     <= '0;
        rem_r     <= '0;
        hs_r      <= 1'b0;
        hsb_r     <= '0;
      end else if (cfg_index == REG_TGT_FMT) begin
        tgt_fmt_r <= cfg_data;
      end
    end else if (acc) begin
      pcp_r <= pcp_nxt;
      rem_r <= rem_nxt;
      hs_r  <= hs_nxt;
      hsb_r <= hsb_nxt;
    end
  end

endmodule

// File: hdl/utc_queue.sv
// Small entry queue between the decoding front and the encoding back.
module utc_queue
  import utc_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  utc_entry_t push_data,
  output logic       full,
  input  logic       pop,
  output logic       not_empty,
  output utc_entry_t head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  utc_entry_t    mem_r [DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r;

  assign full      = (cnt_r == FULL_CNT);
  assign not_empty = (cnt_r != '0);
  assign head      = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == LAST_PTR) ? '0 : wp_r + PW'(1);
      end
      if (pop) begin
        rp_r <= (rp_r == LAST_PTR) ? '0 : rp_r + PW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

endmodule

// File: hdl/utc_back.sv
// Back end: encodes queued codepoints to target units, one per ready cycle.
module utc_back
  import utc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic [1:0] tgt_fmt,
  input  logic       q_vld,
  input  utc_entry_t head,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output utc_out_t   out_data
);

  logic [31:0] eu [4];
  logic [2:0]  en;
  logic [31:0] su [4];
  logic [3:0]  se;
  logic [2:0]  cnt;
  logic [2:0]  j;
  logic [20:0] v;
  logic [20:0] cp;

  logic [1:0]  idx_r;
  logic        out_vld_r;
  utc_out_t    out_r;
  logic        adv, last;

  assign cp = head.cp;
  assign v  = cp - CP_SUPP;

  // Target encoding of the codepoint
  always_comb begin
    eu[0] = QMARK;
    eu[1] = '0;
    eu[2] = '0;
    eu[3] = '0;
    en    = 3'd1;
    if (!head.cp_big) begin
      case (tgt_fmt)
        FMT_UTF8: begin
          if (cp <= 21'h7F) begin
            eu[0] = {11'd0, cp};
          end else if (cp <= 21'h7FF) begin
            eu[0] = {24'd0, 3'b110, cp[10:6]};
            eu[1] = {24'd0, 2'b10, cp[5:0]};
            en    = 3'd2;
          end else if (cp <= 21'hFFFF) begin
            eu[0] = {24'd0, 4'b1110, cp[15:12]};
            eu[1] = {24'd0, 2'b10, cp[11:6]};
            eu[2] = {24'd0, 2'b10, cp[5:0]};
            en    = 3'd3;
          end else begin
            eu[0] = {24'd0, 5'b11110, cp[20:18]};
            eu[1] = {24'd0, 2'b10, cp[17:12]};
            eu[2] = {24'd0, 2'b10, cp[11:6]};
            eu[3] = {24'd0, 2'b10, cp[5:0]};
            en    = 3'd4;
          end
        end
        FMT_UTF16: begin
          if (cp[20:11] == 10'b0000011011) begin
            eu[0] = QMARK;  // surrogate range has no UTF-16 form
          end else if (cp <= 21'hFFFF) begin
            eu[0] = {11'd0, cp};
          end else begin
            eu[0] = {16'd0, 6'b110110, v[19:10]};
            eu[1] = {16'd0, 6'b110111, v[9:0]};
            en    = 3'd2;
          end
        end
        default: eu[0] = {11'd0, cp};
      endcase
    end
    if (!head.cp_vld) begin
      en = 3'd0;
    end
  end

  // Lay out the whole run: optional error, encoded units, optional error
  always_comb begin
    j = '0;
    for (int k = 0; k < 4; k++) begin
      su[k] = QMARK;
      se[k] = 1'b1;
      if (!(head.pre_err && k == 0)) begin
        j = 3'(k) - {2'd0, head.pre_err};
        if (j < en) begin
          su[k] = eu[j[1:0]];
          se[k] = 1'b0;
        end
      end
    end
    cnt = {2'd0, head.pre_err} + en + {2'd0, head.post_err};
  end

  assign adv  = q_vld && (!out_vld_r || out_ready);
  assign last = ({1'b0, idx_r} == cnt - 3'd1);
  assign pop  = adv && last;

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r.out_unit    <= su[idx_r];
      out_r.error       <= se[idx_r];
      out_r.last_of_run <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
      idx_r     <= '0;
    end else begin
      if (adv) begin
        out_vld_r <= 1'b1;
        idx_r     <= last ? 2'd0 : idx_r + 2'd1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

endmodule

// File: hdl/unicode_transcoder_top.sv
// Top level of the streaming UTF-8 / UTF-16 / UTF-32 transcoder.
//
// Input channel (in_valid/in_ready/in_data): one source code unit per beat,
// with end_of_text on the last unit of a text. Output channel
// (out_valid/out_ready/out_data): one target unit per beat, last_of_run set
// on the final unit caused by an input beat, error set on a '?' that stands
// for an invalid or truncated sequence. Inputs that only extend a pending
// sequence produce no output beat.
// Configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data): index 0 is
// the source format, index 1 the target format; cfg_ready is always high.
// A source format write clears any partial sequence.
// Throughput: one input beat per cycle and one output beat per cycle while
// out_ready is high; an input of N units holds the encoder until all N are
// sent. The decoder pushes into a QDEPTH-entry queue, whose head reaches
// out_data through an output register; in_ready drops only on a full queue.
// Reset: formats return to UTF-8 in, UTF-16 out, decode state and queue are
// emptied. A stalled receiver holds the output register and the queue fills.
module unicode_transcoder_top
  import utc_pkg::*;
#(
  parameter int QDEPTH = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  utc_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output utc_out_t              out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic       q_full, q_vld, push, pop;
  utc_entry_t entry, head;
  logic [1:0] tgt_fmt;

  assign cfg_ready = 1'b1;
  assign in_ready  = !q_full;

  utc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .acc       (in_valid && in_ready),
    .in_data   (in_data),
    .push      (push),
    .entry     (entry),
    .tgt_fmt   (tgt_fmt)
  );

  utc_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (entry),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_vld),
    .head      (head)
  );

  utc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .tgt_fmt   (tgt_fmt),
    .q_vld     (q_vld),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
